// ----- design/fec_pkg.sv -----
// Shared types, status codes and CRC-32 helpers for the file envelope checker.
package fec_pkg;

	localparam int unsigned HDR_LEN   = 16;
	localparam int unsigned CNT_W     = 33;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_BOM     = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_TRAILING  = 3'd2;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
	localparam logic [2:0] ST_BAD_VER   = 3'd4;
	localparam logic [2:0] ST_BAD_BOM   = 3'd5;
	localparam logic [2:0] ST_BAD_CRC   = 3'd6;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] payload_length;
		logic [31:0] computed_crc;
	} out_t;

	typedef struct packed {
		logic [31:0] expected_magic;
		logic [15:0] expected_version;
		logic [15:0] byte_order_mark;
	} fec_cfg_t;

	function automatic logic [31:0] crc_nib_tab(input logic [3:0] idx);
		logic [31:0] val;
		case (idx)
			4'h0: val = 32'h0000_0000;
			4'h1: val = 32'h1DB7_1064;
			4'h2: val = 32'h3B6E_20C8;
			4'h3: val = 32'h26D9_30AC;
			4'h4: val = 32'h76DC_4190;
			4'h5: val = 32'h6B6B_51F4;
			4'h6: val = 32'h4DB2_6158;
			4'h7: val = 32'h5005_713C;
			4'h8: val = 32'hEDB8_8320;
			4'h9: val = 32'hF00F_9344;
			4'hA: val = 32'hD6D6_A3E8;
			4'hB: val = 32'hCB61_B38C;
			4'hC: val = 32'h9B64_C2B0;
			4'hD: val = 32'h86D3_D2D4;
			4'hE: val = 32'hA00A_E278;
			default: val = 32'hBDBD_F21C;
		endcase
		return val;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c1;
		c1 = (crc >> 4) ^ crc_nib_tab(crc[3:0] ^ b[3:0]);
		return (c1 >> 4) ^ crc_nib_tab(c1[3:0] ^ b[7:4]);
	endfunction

endpackage

// ----- design/fec_regs.sv -----
// APB configuration registers of the file envelope checker.
module fec_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fec_pkg::PADDR_W-1:0]   paddr,
	input  logic [fec_pkg::PDATA_W-1:0]   pwdata,
	output logic [fec_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output fec_pkg::fec_cfg_t             cfg
);

	fec_pkg::fec_cfg_t cfg_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				fec_pkg::REG_MAGIC:   cfg_q.expected_magic   <= pwdata;
				fec_pkg::REG_VERSION: cfg_q.expected_version <= pwdata[15:0];
				fec_pkg::REG_BOM:     cfg_q.byte_order_mark  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fec_pkg::REG_MAGIC:   prdata = cfg_q.expected_magic;
			fec_pkg::REG_VERSION: prdata = {16'd0, cfg_q.expected_version};
			fec_pkg::REG_BOM:     prdata = {16'd0, cfg_q.byte_order_mark};
			default:              prdata = '0;
		endcase
	end

endmodule

// ----- design/fec_core.sv -----
// Per-file state (byte counter, header bytes, running CRC) and the status evaluation.
module fec_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  fec_pkg::in_t      beat,
	input  fec_pkg::fec_cfg_t cfg,
	output fec_pkg::out_t     res
);

	localparam int unsigned CW = fec_pkg::CNT_W;

	logic [CW-1:0] cnt_q;
	logic [7:0]    hdr_q [fec_pkg::HDR_LEN];
	logic [31:0]   crc_q;

	logic [CW-1:0] cnt_nxt;
	logic [CW-1:0] after;
	logic [7:0]    hdr_nxt [fec_pkg::HDR_LEN];
	logic [31:0]   crc_nxt;
	logic [31:0]   crc_out;
	logic          in_hdr;
	logic          hdr_done;
	logic [31:0]   magic;
	logic [15:0]   version;
	logic [15:0]   bom;
	logic [31:0]   length;
	logic [31:0]   stored_crc;

	assign in_hdr  = (cnt_q[CW-1:4] == '0);
	assign cnt_nxt = (&cnt_q) ? cnt_q : cnt_q + CW'(1);
	assign crc_nxt = in_hdr ? crc_q : fec_pkg::crc_byte(crc_q, beat.file_byte);
	assign crc_out = ~crc_nxt;

	always_comb begin
		for (int i = 0; i < fec_pkg::HDR_LEN; i++) begin
			hdr_nxt[i] = (in_hdr && cnt_q[3:0] == 4'(i)) ? beat.file_byte : hdr_q[i];
		end
	end

	assign hdr_done   = (cnt_nxt[CW-1:4] != '0);
	assign after      = cnt_nxt - CW'(fec_pkg::HDR_LEN);
	assign magic      = {hdr_nxt[3], hdr_nxt[2], hdr_nxt[1], hdr_nxt[0]};
	assign version    = {hdr_nxt[5], hdr_nxt[4]};
	assign bom        = {hdr_nxt[7], hdr_nxt[6]};
	assign length     = {hdr_nxt[11], hdr_nxt[10], hdr_nxt[9], hdr_nxt[8]};
	assign stored_crc = {hdr_nxt[15], hdr_nxt[14], hdr_nxt[13], hdr_nxt[12]};

	always_comb begin
		res.computed_crc   = crc_out;
		res.payload_length = hdr_done ? length : 32'd0;
		if (!hdr_done) begin
			res.status = fec_pkg::ST_TRUNCATED;
		end else if (magic != cfg.expected_magic) begin
			res.status = fec_pkg::ST_BAD_MAGIC;
		end else if (bom != cfg.byte_order_mark) begin
			res.status = fec_pkg::ST_BAD_BOM;
		end else if (version != cfg.expected_version) begin
			res.status = fec_pkg::ST_BAD_VER;
		end else if ({1'b0, length} > after) begin
			res.status = fec_pkg::ST_TRUNCATED;
		end else if ({1'b0, length} < after) begin
			res.status = fec_pkg::ST_TRAILING;
		end else if (stored_crc != crc_out) begin
			res.status = fec_pkg::ST_BAD_CRC;
		end else begin
			res.status = fec_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= fec_pkg::CRC_INIT;
		end else if (take) begin
			if (beat.is_last) begin
				cnt_q <= '0;
				crc_q <= fec_pkg::CRC_INIT;
			end else begin
				cnt_q <= cnt_nxt;
				crc_q <= crc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < fec_pkg::HDR_LEN; i++) begin
				hdr_q[i] <= hdr_nxt[i];
			end
		end
	end

endmodule

// ----- design/file_envelope_checker.sv -----
// Top level of the file envelope checker: input register, checker core and result register.
//
// A file enters one byte per beat on the byte channel (byte_valid, byte_stall,
// byte_beat), with is_last set on its final byte. Every file must carry at least
// one byte. The first 16 bytes are the header; all later bytes feed a CRC-32.
// For each file exactly one beat leaves on the status channel (status_valid,
// status_stall, status_beat), carrying the status code, the header length field
// and the computed CRC.
// A byte is registered at the edge that accepts it and evaluated in the next
// cycle, so a status is presented in the cycle after the last byte is taken.
// The block accepts one byte every cycle while no final byte is stalled; the per-byte CRC
// update and the status compare sit between the input register and the result register.
// When the receiver stalls, only a final byte waits behind the held status;
// other bytes keep flowing. Reset empties both stages, restarts the byte count
// and the CRC, and clears the configuration registers to zero. The user must write
// configuration over the APB port only while idle; the block does not enforce this.
module file_envelope_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  fec_pkg::in_t                  byte_beat,
	output logic                          status_valid,
	input  logic                          status_stall,
	output fec_pkg::out_t                 status_beat,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fec_pkg::PADDR_W-1:0]   paddr,
	input  logic [fec_pkg::PDATA_W-1:0]   pwdata,
	output logic [fec_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	fec_pkg::fec_cfg_t cfg;
	fec_pkg::in_t      beat_s1;
	logic              valid_s1;
	fec_pkg::out_t     res;
	fec_pkg::out_t     res_s2;
	logic              valid_s2;
	logic              slot_free;
	logic              adv;
	logic              take;

	fec_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign slot_free  = !valid_s2 || !status_stall;
	assign adv        = !beat_s1.is_last || slot_free;
	assign take       = valid_s1 && adv;
	assign byte_stall = valid_s1 && !adv;

	fec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.beat   (beat_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (take && beat_s1.is_last) begin
				valid_s2 <= 1'b1;
			end else if (!status_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			beat_s1 <= byte_beat;
		end
		if (take && beat_s1.is_last) begin
			res_s2 <= res;
		end
	end

	assign status_valid = valid_s2;
	assign status_beat  = res_s2;

endmodule
